// ===== rtl/stl_pkg.sv =====
`default_nettype none

package stl_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CASE_GAP  = 8'd32;

  // Token kinds
  localparam logic [4:0] KIND_IDENT  = 5'd22;
  localparam logic [4:0] KIND_STRING = 5'd23;
  localparam logic [4:0] KIND_INT    = 5'd24;
  localparam logic [4:0] KIND_FLOAT  = 5'd25;
  localparam logic [4:0] KIND_STAR   = 5'd26;
  localparam logic [4:0] KIND_COMMA  = 5'd27;
  localparam logic [4:0] KIND_SEMI   = 5'd28;
  localparam logic [4:0] KIND_LPAREN = 5'd29;
  localparam logic [4:0] KIND_RPAREN = 5'd30;
  localparam logic [4:0] KIND_EQUALS = 5'd31;

  // Keyword table, text left-justified and zero padded
  localparam int NUM_KW     = 22;
  localparam int KW_MAX_LEN = 9;

  typedef logic [8*KW_MAX_LEN-1:0] kw_text_t;

  localparam kw_text_t KW_TEXT [NUM_KW] = '{
    {"database", 8'h00}, {"show", 40'h0}, {"databases"}, {"use", 48'h0},
    {"select", 24'h0}, {"insert", 24'h0}, {"values", 24'h0}, {"from", 40'h0},
    {"into", 40'h0}, {"create", 24'h0}, {"table", 32'h0}, {"int", 48'h0},
    {"text", 40'h0}, {"float", 32'h0}, {"null", 40'h0}, {"primary", 16'h0},
    {"key", 48'h0}, {"unique", 24'h0}, {"delete", 24'h0}, {"update", 24'h0},
    {"set", 48'h0}, {"where", 32'h0}
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd8, 4'd4, 4'd9, 4'd3, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4, 4'd6, 4'd5,
    4'd3, 4'd4, 4'd5, 4'd4, 4'd7, 4'd3, 4'd6, 4'd6, 4'd6, 4'd3, 4'd5
  };

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_WORD = 3'b010,
    MODE_STR  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        err;
    logic        last;
  } result_t;

  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== rtl/stl_in_if.sv =====
`default_nettype none

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== rtl/stl_out_if.sv =====
`default_nettype none

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        error_flag;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output error_flag, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input error_flag, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/sql_token_lexer_unit.sv =====
// SQL token lexer. Takes one statement byte per input transfer (end_of_input
// on the final byte) and reports each token as kind, start position and
// length. A byte is taken every cycle while the input is ready; it is classified by
// combinational logic (whitespace, symbol, quote, keyword compare on the buffered word
// prefix) and its zero, one or two tokens are written into a four-entry result queue
// in the same cycle. The queue drains one token per cycle while the output is ready,
// and the input stays ready while at least two queue slots are free, so a stream of
// bytes runs at one byte per cycle except where the queue fills; a symbol that closes
// a word yields two tokens. Positions and lengths saturate at 2^POSITION_BITS - 1
// and are reported in their low 16 bits; the position restarts at zero after each
// end of statement.
`default_nettype none

module sql_token_lexer_unit #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_CHARS = 9
) (
  input  logic      clk,
  input  logic      rst_n,
  stl_in_if.sink    in_chan,
  stl_out_if.source out_chan
);

  localparam int P     = POSITION_BITS;
  localparam int EXT_W = 33;
  localparam int QD    = stl_pkg::QUEUE_DEPTH;
  localparam int QA    = $clog2(QD);

  typedef logic [P-1:0] pos_t;

  // saturating increment of a position or length
  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic logic [EXT_W-1:0] ext(input pos_t v);
    return {{(EXT_W-P){1'b0}}, v};
  endfunction

  // lexer state
  stl_pkg::mode_t mode_r, mode_nxt;
  pos_t           pos_r, start_r, start_nxt, len_r, len_nxt, add_base;
  logic           digit_r, digit_nxt, dot_r, dot_nxt;
  logic [7:0]     prefix_r   [KEYWORD_CHARS];
  logic [7:0]     prefix_nxt [KEYWORD_CHARS];

  // classification of the incoming byte
  logic [7:0] ch;
  logic       eoi, is_space, is_quote, sym_hit, add_char;
  logic [4:0] sym_kind, word_kind;
  logic       emit_word, emit_sym, emit_str, eoi_word, eoi_str;
  logic       in_fire;

  stl_pkg::result_t res0, res1;
  logic             res0_v, res1_v;

  // result queue
  stl_pkg::result_t q_r [QD];
  logic [QA-1:0]    head_r, tail_r;
  logic [QA:0]      count_r;
  logic             pop;
  logic [QA:0]      n_push;

  assign ch       = in_chan.char_code;
  assign eoi      = in_chan.end_of_input;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign is_space = (ch == stl_pkg::CH_SPACE) ||
                    (ch >= stl_pkg::CH_TAB && ch <= stl_pkg::CH_CR);
  assign is_quote = (ch == stl_pkg::CH_QUOTE);

  always_comb begin
    sym_hit  = 1'b1;
    sym_kind = stl_pkg::KIND_STAR;
    case (ch)
      stl_pkg::CH_STAR:   sym_kind = stl_pkg::KIND_STAR;
      stl_pkg::CH_COMMA:  sym_kind = stl_pkg::KIND_COMMA;
      stl_pkg::CH_SEMI:   sym_kind = stl_pkg::KIND_SEMI;
      stl_pkg::CH_LPAREN: sym_kind = stl_pkg::KIND_LPAREN;
      stl_pkg::CH_RPAREN: sym_kind = stl_pkg::KIND_RPAREN;
      stl_pkg::CH_EQUALS: sym_kind = stl_pkg::KIND_EQUALS;
      default:            sym_hit  = 1'b0;
    endcase
  end

  // next lexer state for this byte, before the end-of-statement clear
  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    digit_nxt = digit_r;
    dot_nxt   = dot_r;
    add_char  = 1'b0;
    emit_word = 1'b0;
    emit_sym  = 1'b0;
    emit_str  = 1'b0;
    case (mode_r)
      stl_pkg::MODE_IDLE: begin
        if (is_space) begin
          mode_nxt = stl_pkg::MODE_IDLE;
        end else if (sym_hit) begin
          emit_sym = 1'b1;
        end else if (is_quote) begin
          mode_nxt  = stl_pkg::MODE_STR;
          start_nxt = pos_r;
          len_nxt   = '0;
        end else begin
          mode_nxt  = stl_pkg::MODE_WORD;
          start_nxt = pos_r;
          len_nxt   = '0;
          dot_nxt   = 1'b0;
          digit_nxt = (ch >= stl_pkg::CH_ZERO) && (ch <= stl_pkg::CH_NINE);
          add_char  = 1'b1;
        end
      end
      stl_pkg::MODE_WORD: begin
        if (is_space || sym_hit) begin
          emit_word = 1'b1;
          emit_sym  = sym_hit;
          mode_nxt  = stl_pkg::MODE_IDLE;
        end else begin
          add_char = 1'b1;
        end
      end
      stl_pkg::MODE_STR: begin
        if (is_quote) begin
          emit_str = 1'b1;
          mode_nxt = stl_pkg::MODE_IDLE;
        end else begin
          len_nxt = sat_inc(len_r);
        end
      end
      default: mode_nxt = stl_pkg::MODE_IDLE;
    endcase
    add_base = len_nxt;
    if (add_char) begin
      if (ch == stl_pkg::CH_DOT) dot_nxt = 1'b1;
      len_nxt = sat_inc(len_nxt);
    end
  end

  // buffer the first KEYWORD_CHARS bytes of the word
  always_comb begin
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      prefix_nxt[i] = (add_char && ext(add_base) == EXT_W'(i)) ? ch : prefix_r[i];
    end
  end

  // keyword compare on the updated word; lowest keyword index wins
  always_comb begin
    logic lo_ok, up_ok;
    logic [7:0] kc;
    word_kind = digit_nxt ? (dot_nxt ? stl_pkg::KIND_FLOAT : stl_pkg::KIND_INT)
                          : stl_pkg::KIND_IDENT;
    for (int k = stl_pkg::NUM_KW - 1; k >= 0; k--) begin
      lo_ok = (ext(len_nxt) == EXT_W'(stl_pkg::KW_LEN[k]));
      up_ok = lo_ok;
      for (int i = 0; i < stl_pkg::KW_MAX_LEN; i++) begin
        kc = stl_pkg::KW_TEXT[k][8*stl_pkg::KW_MAX_LEN-1-8*i -: 8];
        if (i < int'(stl_pkg::KW_LEN[k])) begin
          if (prefix_nxt[i] != kc) lo_ok = 1'b0;
          if (prefix_nxt[i] != kc - stl_pkg::CASE_GAP) up_ok = 1'b0;
        end
      end
      if (lo_ok || up_ok) word_kind = 5'(k);
    end
  end

  // assemble up to two tokens: a closed word or string first, then a symbol
  assign eoi_word = eoi && (mode_nxt == stl_pkg::MODE_WORD);
  assign eoi_str  = eoi && (mode_nxt == stl_pkg::MODE_STR);

  always_comb begin
    res0_v = emit_word || emit_str || emit_sym || eoi_word || eoi_str;
    res1_v = emit_word && emit_sym;
    res0   = '{kind: word_kind, start: 16'(start_nxt), length: 16'(len_nxt),
               err: 1'b0, last: 1'b0};
    if (emit_str || eoi_str) begin
      res0.kind = stl_pkg::KIND_STRING;
      res0.err  = eoi_str;
    end else if (emit_sym && !emit_word) begin
      res0.kind   = sym_kind;
      res0.start  = 16'(pos_r);
      res0.length = 16'd1;
    end
    res0.last = !res1_v;
    res1 = '{kind: sym_kind, start: 16'(pos_r), length: 16'd1, err: 1'b0, last: 1'b1};
  end

  // lexer registers: advance on each input transfer, restart after end of statement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stl_pkg::MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      digit_r <= 1'b0;
      dot_r   <= 1'b0;
    end else if (in_fire) begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
      if (eoi) begin
        mode_r  <= stl_pkg::MODE_IDLE;
        pos_r   <= '0;
        digit_r <= 1'b0;
        dot_r   <= 1'b0;
      end else begin
        mode_r  <= mode_nxt;
        pos_r   <= sat_inc(pos_r);
        digit_r <= digit_nxt;
        dot_r   <= dot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < KEYWORD_CHARS; i++) prefix_r[i] <= prefix_nxt[i];
    end
  end

  // result queue: push up to two per transfer, drain one per cycle while the output is ready
  assign pop    = out_chan.valid && out_chan.ready;
  assign n_push = in_fire ? ((QA+1)'(res0_v) + (QA+1)'(res1_v)) : '0;

  always_ff @(posedge clk) begin
    for (int e = 0; e < QD; e++) begin
      if (in_fire && res0_v && tail_r == QA'(e)) begin
        q_r[e] <= res0;
      end else if (in_fire && res1_v && QA'(tail_r + QA'(1)) == QA'(e)) begin
        q_r[e] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + n_push[QA-1:0];
      head_r  <= head_r + QA'(pop);
      count_r <= count_r + n_push - (QA+1)'(pop);
    end
  end

  // hold input while fewer than two slots are free
  assign in_chan.ready = (count_r <= (QA+1)'(QD - 2));

  assign out_chan.valid        = (count_r != '0);
  assign out_chan.token_kind   = q_r[head_r].kind;
  assign out_chan.token_start  = q_r[head_r].start;
  assign out_chan.token_length = q_r[head_r].length;
  assign out_chan.error_flag   = q_r[head_r].err;
  assign out_chan.last_of_run  = q_r[head_r].last;

endmodule

`default_nettype wire

// ===== rtl/stl_checker.sv =====
`default_nettype none

module stl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  token_kind,
  input wire logic [15:0] token_start,
  input wire logic [15:0] token_length,
  input wire logic        error_flag,
  input wire logic        last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
      $stable(token_start) && $stable(token_length) && $stable(error_flag) &&
      $stable(last_of_run))
    else $error("result changed while stalled");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented after reset");

  // an error is always an unterminated string and ends its run
  a_err_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_flag |-> token_kind == stl_pkg::KIND_STRING && last_of_run)
    else $error("error flag on a non-string or non-final token");

  // symbol tokens are one character long
  a_sym_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind >= stl_pkg::KIND_STAR |-> token_length == 16'd1 && !error_flag)
    else $error("symbol token with wrong length");

  // an idle, ready lexer with no input presents nothing new
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("result appeared without an input transfer");

endmodule

bind sql_token_lexer_unit stl_checker u_stl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .token_kind   (out_chan.token_kind),
  .token_start  (out_chan.token_start),
  .token_length (out_chan.token_length),
  .error_flag   (out_chan.error_flag),
  .last_of_run  (out_chan.last_of_run)
);

`default_nettype wire

// ===== tb/sql_token_lexer_unit_test.sv =====
`default_nettype none

module sql_token_lexer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits. About 900 bytes go in; the slowest correct byte waits out an
  // input gap and then two tokens that each sit behind an output stall, so
  // the limit is set well above that worst case.
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int          RANDOM_CHARS = 740;
  localparam int          MAX_WAIT     = 10;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          RESET_CYCLES = 11;

  // Matches the block's default sizing: 16-bit positions, 9-byte word prefix
  localparam int          PREFIX_CHARS = 9;
  localparam logic [15:0] POS_CEIL     = 16'hFFFF;
  localparam int          KW_COUNT     = 22;

  // Keyword kinds used by the hand-typed rows
  localparam logic [4:0]  KW_DATABASE  = 5'd0;
  localparam logic [4:0]  KW_DATABASES = 5'd2;
  localparam logic [4:0]  KW_WHERE     = 5'd21;

  // Returned for bytes that are not one of the six symbol characters
  localparam logic [4:0]  NOT_SYMBOL   = 5'd0;

  logic clk = 1'b0;
  logic rst_n;

  stl_in_if  in_chan ();
  stl_out_if out_chan ();

  sql_token_lexer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Lexer predictor: its own copy of the mode, position and current-token state
  // ---------------------------------------------------------------------------
  stl_pkg::mode_t   lx_mode;
  logic [15:0]      lx_pos;
  logic [15:0]      word_start;
  logic [15:0]      word_len;
  logic [7:0]       word_head [PREFIX_CHARS];
  bit               digit_first;
  bit               dot_seen;

  stl_pkg::result_t step_tokens[$];     // tokens caused by the byte just lexed
  stl_pkg::result_t expected_tokens[$]; // tokens still to come out of the block

  function automatic string kw_spelling(int k);
    case (k)
      0:  return "database";
      1:  return "show";
      2:  return "databases";
      3:  return "use";
      4:  return "select";
      5:  return "insert";
      6:  return "values";
      7:  return "from";
      8:  return "into";
      9:  return "create";
      10: return "table";
      11: return "int";
      12: return "text";
      13: return "float";
      14: return "null";
      15: return "primary";
      16: return "key";
      17: return "unique";
      18: return "delete";
      19: return "update";
      20: return "set";
      default: return "where";
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == stl_pkg::CH_SPACE || (c >= stl_pkg::CH_TAB && c <= stl_pkg::CH_CR);
  endfunction

  function automatic logic [4:0] symbol_of(logic [7:0] c);
    case (c)
      stl_pkg::CH_STAR:   return stl_pkg::KIND_STAR;
      stl_pkg::CH_COMMA:  return stl_pkg::KIND_COMMA;
      stl_pkg::CH_SEMI:   return stl_pkg::KIND_SEMI;
      stl_pkg::CH_LPAREN: return stl_pkg::KIND_LPAREN;
      stl_pkg::CH_RPAREN: return stl_pkg::KIND_RPAREN;
      stl_pkg::CH_EQUALS: return stl_pkg::KIND_EQUALS;
      default:            return NOT_SYMBOL;
    endcase
  endfunction

  // Saturating count, held at the top of the 16-bit range
  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == POS_CEIL) ? v : v + 16'd1;
  endfunction

  function automatic stl_pkg::result_t tok(logic [4:0] kind, logic [15:0] start,
                                           logic [15:0] len, logic err, logic last);
    return {kind, start, len, err, last};
  endfunction

  function void note(logic [4:0] kind, logic [15:0] start, logic [15:0] len, logic err);
    step_tokens.insert(step_tokens.size(), tok(kind, start, len, err, 1'b0));
  endfunction

  // Keyword if the buffered head matches one spelled all-lower or all-upper;
  // otherwise a number when it opened with a digit, else an identifier.
  function logic [4:0] classify_word();
    string      kw;
    bit         lo;
    bit         up;
    logic [7:0] kc;
    if (word_len <= PREFIX_CHARS) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        kw = kw_spelling(k);
        if (kw.len() == word_len) begin
          lo = 1'b1;
          up = 1'b1;
          for (int i = 0; i < kw.len(); i++) begin
            kc = kw[i];
            if (word_head[i] != kc) lo = 1'b0;
            if (word_head[i] != kc - stl_pkg::CASE_GAP) up = 1'b0;
          end
          if (lo || up) return 5'(k);
        end
      end
    end
    if (digit_first) return dot_seen ? stl_pkg::KIND_FLOAT : stl_pkg::KIND_INT;
    return stl_pkg::KIND_IDENT;
  endfunction

  function void take_word_char(logic [7:0] c);
    if (word_len < PREFIX_CHARS) word_head[word_len[3:0]] = c;
    if (c == stl_pkg::CH_DOT) dot_seen = 1'b1;
    word_len = bump(word_len);
  endfunction

  function void reset_lexer();
    lx_mode     = stl_pkg::MODE_IDLE;
    lx_pos      = '0;
    word_start  = '0;
    word_len    = '0;
    digit_first = 1'b0;
    dot_seen    = 1'b0;
    foreach (word_head[i]) word_head[i] = '0;
  endfunction

  // Advance the predictor by one byte and leave its tokens in step_tokens
  function void lex_char(logic [7:0] c, bit eoi);
    logic [4:0]  sym;
    logic [15:0] here;
    step_tokens.delete();
    sym  = symbol_of(c);
    here = lx_pos;
    case (lx_mode)
      stl_pkg::MODE_IDLE: begin
        if (is_blank(c)) begin
        end else if (sym != NOT_SYMBOL) begin
          note(sym, here, 16'd1, 1'b0);
        end else if (c == stl_pkg::CH_QUOTE) begin
          lx_mode    = stl_pkg::MODE_STR;
          word_start = here;
          word_len   = '0;
        end else begin
          lx_mode     = stl_pkg::MODE_WORD;
          word_start  = here;
          word_len    = '0;
          dot_seen    = 1'b0;
          digit_first = (c >= stl_pkg::CH_ZERO && c <= stl_pkg::CH_NINE);
          take_word_char(c);
        end
      end
      stl_pkg::MODE_WORD: begin
        // Whitespace or a symbol closes the word; the symbol follows it
        if (is_blank(c) || sym != NOT_SYMBOL) begin
          note(classify_word(), word_start, word_len, 1'b0);
          lx_mode = stl_pkg::MODE_IDLE;
          if (sym != NOT_SYMBOL) note(sym, here, 16'd1, 1'b0);
        end else begin
          take_word_char(c);
        end
      end
      default: begin
        if (c == stl_pkg::CH_QUOTE) begin
          note(stl_pkg::KIND_STRING, word_start, word_len, 1'b0);
          lx_mode = stl_pkg::MODE_IDLE;
        end else begin
          word_len = bump(word_len);
        end
      end
    endcase

    // End of statement: flush any open word, flag an open string, restart
    if (eoi) begin
      if (lx_mode == stl_pkg::MODE_WORD)
        note(classify_word(), word_start, word_len, 1'b0);
      else if (lx_mode == stl_pkg::MODE_STR)
        note(stl_pkg::KIND_STRING, word_start, word_len, 1'b1);
      lx_mode     = stl_pkg::MODE_IDLE;
      lx_pos      = '0;
      digit_first = 1'b0;
      dot_seen    = 1'b0;
    end else begin
      lx_pos = bump(here);
    end

    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  bit steady = 1'b0;  // when set, neither side idles

  // Lex the byte, queue its tokens if scored, then hold it until the transfer
  task automatic send_char(logic [7:0] c, bit eoi, bit scored);
    int gap;
    lex_char(c, eoi);
    if (scored)
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid        <= 1'b1;
    in_chan.char_code    <= c;
    in_chan.end_of_input <= eoi;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_text(string s, bit scored);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, scored);
  endtask

  // ---------------------------------------------------------------------------
  // Random statement builder
  // ---------------------------------------------------------------------------
  logic [7:0] stmt[$];

  function void put_byte(logic [7:0] c);
    stmt.insert(stmt.size(), c);
  endfunction

  function automatic logic [7:0] any_but_quote();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == stl_pkg::CH_QUOTE);
    return c;
  endfunction

  // A byte that continues a word; quotes count as plain characters here
  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_blank(c) || symbol_of(c) != NOT_SYMBOL);
    return c;
  endfunction

  function automatic logic [7:0] digit();
    return stl_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function void put_blank();
    int k;
    k = $urandom_range(0, 5);
    put_byte(k == 5 ? stl_pkg::CH_SPACE : stl_pkg::CH_TAB + 8'(k));
  endfunction

  // Lower, upper or mixed case; mixed spellings must come out as identifiers
  function void put_keyword();
    string      kw;
    int         style;
    logic [7:0] c;
    kw    = kw_spelling($urandom_range(0, KW_COUNT - 1));
    style = $urandom_range(0, 9);
    for (int i = 0; i < kw.len(); i++) begin
      c = kw[i];
      if (style >= 5 && (style < 9 || $urandom_range(0, 1) == 1)) c = c - stl_pkg::CASE_GAP;
      put_byte(c);
    end
  endfunction

  function void put_token();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: put_keyword();
      3: begin
        do c = word_byte(); while (c == stl_pkg::CH_QUOTE);
        put_byte(c);
        repeat ($urandom_range(0, 12)) put_byte(word_byte());
      end
      4: repeat ($urandom_range(1, 6)) put_byte(digit());
      5: begin
        repeat ($urandom_range(1, 4)) put_byte(digit());
        repeat ($urandom_range(1, 2)) begin
          put_byte(stl_pkg::CH_DOT);
          repeat ($urandom_range(0, 3)) put_byte(digit());
        end
      end
      6: begin
        put_byte(stl_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 8)) put_byte(any_but_quote());
        put_byte(stl_pkg::CH_QUOTE);
      end
      7: begin
        case ($urandom_range(0, 5))
          0: put_byte(stl_pkg::CH_STAR);
          1: put_byte(stl_pkg::CH_COMMA);
          2: put_byte(stl_pkg::CH_SEMI);
          3: put_byte(stl_pkg::CH_LPAREN);
          4: put_byte(stl_pkg::CH_RPAREN);
          default: put_byte(stl_pkg::CH_EQUALS);
        endcase
      end
      8: put_byte(8'($urandom_range(0, 255)));
      default: begin
        // Near miss: a keyword with a tail, which matches only if it spells a longer keyword
        put_keyword();
        put_byte(word_byte());
      end
    endcase
  endfunction

  function void build_statement();
    stmt.delete();
    repeat ($urandom_range(1, 8)) begin
      put_token();
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 2)) put_blank();
    end
    // Now and then leave a string open at the end of the statement
    if ($urandom_range(0, 9) == 0) begin
      put_byte(stl_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 5)) put_byte(any_but_quote());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls and the token checker
  // ---------------------------------------------------------------------------
  int fail_count  = 0;
  int token_count = 0;
  int stall_left  = 0;
  bit took_token  = 1'b0;

  task automatic report(string field, longint got, longint want);
    $display("token %0d: %s got %0d, want %0d", token_count, field, got, want);
    fail_count++;
  endtask

  // Draw a fresh stall after every transfer; hold ready low while it runs out
  always @(negedge clk) begin
    if (took_token) begin
      took_token = 1'b0;
      stall_left = steady ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Compare each transfer with the oldest expected token, field by field
  always @(posedge clk) begin
    stl_pkg::result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      took_token = 1'b1;
      if (expected_tokens.size() == 0) begin
        report("unexpected token of kind", out_chan.token_kind, -1);
      end else begin
        want = expected_tokens.pop_front();
        if (out_chan.token_kind != want.kind)
          report("kind", out_chan.token_kind, want.kind);
        if (out_chan.token_start != want.start)
          report("start", out_chan.token_start, want.start);
        if (out_chan.token_length != want.length)
          report("length", out_chan.token_length, want.length);
        if (out_chan.error_flag != want.err)
          report("error flag", out_chan.error_flag, want.err);
        if (out_chan.last_of_run != want.last)
          report("last of run", out_chan.last_of_run, want.last);
      end
      token_count++;
    end
  end

  // Hard stop if the block hangs
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding",
               cycle_count, expected_tokens.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows: a statement each, with its tokens typed in where they are
  // obvious; the rest are scored by the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    string            text;
    bit               typed;
    int               count;
    stl_pkg::result_t first;
    stl_pkg::result_t second;
  } row_t;

  row_t rows[$];

  function void add_row(string text, bit typed, int count, stl_pkg::result_t first,
                        stl_pkg::result_t second);
    row_t r;
    r.text   = text;
    r.typed  = typed;
    r.count  = count;
    r.first  = first;
    r.second = second;
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    int random_sent;

    in_chan.valid        = 1'b0;
    in_chan.char_code    = '0;
    in_chan.end_of_input = 1'b0;
    out_chan.ready       = 1'b0;
    rst_n                = 1'b0;
    reset_lexer();

    // Every symbol alone
    add_row("*", 1'b1, 1, tok(stl_pkg::KIND_STAR,   16'd0, 16'd1, 1'b0, 1'b1), '0);
    add_row(",", 1'b1, 1, tok(stl_pkg::KIND_COMMA,  16'd0, 16'd1, 1'b0, 1'b1), '0);
    add_row(";", 1'b1, 1, tok(stl_pkg::KIND_SEMI,   16'd0, 16'd1, 1'b0, 1'b1), '0);
    add_row("(", 1'b1, 1, tok(stl_pkg::KIND_LPAREN, 16'd0, 16'd1, 1'b0, 1'b1), '0);
    add_row(")", 1'b1, 1, tok(stl_pkg::KIND_RPAREN, 16'd0, 16'd1, 1'b0, 1'b1), '0);
    add_row("=", 1'b1, 1, tok(stl_pkg::KIND_EQUALS, 16'd0, 16'd1, 1'b0, 1'b1), '0);
    // Keywords: both cases, the longest, one too long, one in mixed case
    add_row("where",      1'b1, 1, tok(KW_WHERE,     16'd0, 16'd5,  1'b0, 1'b1), '0);
    add_row("DATABASE",   1'b1, 1, tok(KW_DATABASE,  16'd0, 16'd8,  1'b0, 1'b1), '0);
    add_row("databases",  1'b1, 1, tok(KW_DATABASES, 16'd0, 16'd9,  1'b0, 1'b1), '0);
    add_row("databasesx", 1'b1, 1,
            tok(stl_pkg::KIND_IDENT, 16'd0, 16'd10, 1'b0, 1'b1), '0);
    add_row("Where",      1'b1, 1,
            tok(stl_pkg::KIND_IDENT, 16'd0, 16'd5,  1'b0, 1'b1), '0);
    add_row("  where",    1'b1, 1, tok(KW_WHERE,     16'd2, 16'd5,  1'b0, 1'b1), '0);
    // Numbers, strings, an open string at the end, a symbol closing a word
    add_row("42",  1'b1, 1, tok(stl_pkg::KIND_INT,    16'd0, 16'd2, 1'b0, 1'b1), '0);
    add_row("9.5", 1'b1, 1, tok(stl_pkg::KIND_FLOAT,  16'd0, 16'd3, 1'b0, 1'b1), '0);
    add_row("''",  1'b1, 1, tok(stl_pkg::KIND_STRING, 16'd0, 16'd0, 1'b0, 1'b1), '0);
    add_row("'ab", 1'b1, 1, tok(stl_pkg::KIND_STRING, 16'd0, 16'd2, 1'b1, 1'b1), '0);
    add_row("x(",  1'b1, 2, tok(stl_pkg::KIND_IDENT,  16'd0, 16'd1, 1'b0, 1'b0),
            tok(stl_pkg::KIND_LPAREN, 16'd1, 16'd1, 1'b0, 1'b1));
    // Every whitespace byte, nothing out
    add_row("\011\012\013\014\015 ", 1'b1, 0, '0, '0);
    // Left to the predictor
    add_row("select * from t1 where a=1;", 1'b0, 0, '0, '0);
    add_row("INSERT INTO t VALUES (1,'x y',2.5);", 1'b0, 0, '0, '0);
    add_row("a'b c", 1'b0, 0, '0, '0);
    add_row("\377\200k key", 1'b0, 0, '0, '0);
    add_row("1.2.3 0x1F 'open", 1'b0, 0, '0, '0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) begin
      if (rows[r].typed) begin
        if (rows[r].count > 0) expected_tokens.insert(expected_tokens.size(), rows[r].first);
        if (rows[r].count > 1) expected_tokens.insert(expected_tokens.size(), rows[r].second);
      end
      send_text(rows[r].text, !rows[r].typed);
    end

    // Random statements, with the odd stretch where neither side idles
    random_sent = 0;
    while (random_sent < RANDOM_CHARS) begin
      steady = ($urandom_range(0, 7) == 0);
      build_statement();
      foreach (stmt[i]) send_char(stmt[i], i == stmt.size() - 1, 1'b1);
      random_sent += stmt.size();
    end
    steady = 1'b0;

    @(negedge clk);
    in_chan.valid <= 1'b0;

    // Drain, then give any stray token time to show up
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
